[hw/rtl/mlfd_pkg.sv]
// shared constants and lookup functions of the meter display frame decoder
`timescale 1ns / 1ps

package mlfd_pkg;

    localparam int FRAME_BYTES = 35;
    localparam int DIGIT_COUNT = 6;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // first nibble of the digit field in the store, two nibbles per digit
    localparam int DIGIT_BASE  = 6;
    localparam int WALK_READS  = 2 * DIGIT_COUNT;
    localparam int WALK_W      = $clog2(WALK_READS);

    // character codes of the display string
    localparam logic [3:0] CH_DOT    = 4'd10;
    localparam logic [3:0] CH_MINUS  = 4'd11;
    localparam logic [3:0] CH_LETTER = 4'd12;
    localparam logic [3:0] SEG_NONE  = 4'd15;

    // unit codes
    localparam logic [2:0] UNIT_V   = 3'd0;
    localparam logic [2:0] UNIT_HZ  = 3'd1;
    localparam logic [2:0] UNIT_OHM = 3'd2;
    localparam logic [2:0] UNIT_F   = 3'd3;
    localparam logic [2:0] UNIT_A   = 3'd4;
    localparam logic [2:0] UNIT_DBM = 3'd5;
    localparam logic [2:0] UNIT_PCT = 3'd6;

    // coupling codes
    localparam logic [1:0] COUP_NONE  = 2'd0;
    localparam logic [1:0] COUP_DC    = 2'd1;
    localparam logic [1:0] COUP_AC    = 2'd2;
    localparam logic [1:0] COUP_ACDC  = 2'd3;

    // modifier codes
    localparam logic [2:0] MOD_NONE  = 3'd0;
    localparam logic [2:0] MOD_MIN   = 3'd1;
    localparam logic [2:0] MOD_MAX   = 3'd2;
    localparam logic [2:0] MOD_PP    = 3'd3;
    localparam logic [2:0] MOD_DELTA = 3'd4;

    localparam logic [2:0] UNIT_OF_SWITCH [9] = '{
        UNIT_V, UNIT_V, UNIT_V, UNIT_HZ, UNIT_V, UNIT_OHM, UNIT_F, UNIT_A, UNIT_A
    };

    localparam int OUT_DATA_W = 40;

    // segment pattern to table index, SEG_NONE when unknown
    function automatic logic [3:0] seg_lookup(input logic [6:0] s);
        logic [3:0] k;
        case (s)
            7'h7D:   k = 4'd0;
            7'h05:   k = 4'd1;
            7'h5B:   k = 4'd2;
            7'h1F:   k = 4'd3;
            7'h27:   k = 4'd4;
            7'h3E:   k = 4'd5;
            7'h7E:   k = 4'd6;
            7'h15:   k = 4'd7;
            7'h7F:   k = 4'd8;
            7'h3F:   k = 4'd9;
            7'h7A:   k = 4'd10;
            7'h68:   k = 4'd11;
            7'h46:   k = 4'd12;
            7'h42:   k = 4'd13;
            7'h02:   k = 4'd14;
            default: k = SEG_NONE;
        endcase
        return k;
    endfunction

    // position of the highest set bit plus one, zero for zero
    function automatic logic [2:0] bit_pos(input logic [3:0] v);
        logic [2:0] p;
        if (v[3]) begin
            p = 3'd4;
        end else if (v[2]) begin
            p = 3'd3;
        end else if (v[1]) begin
            p = 3'd2;
        end else if (v[0]) begin
            p = 3'd1;
        end else begin
            p = 3'd0;
        end
        return p;
    endfunction

endpackage

[hw/rtl/meter_lcd_frame_decoder_unit.sv]
// top level of the meter display frame decoder
`timescale 1ns / 1ps

// Decodes one 35-byte display frame of a multimeter optical link. Bytes are
// taken one per cycle on the slave side; the data nibble of each byte after the
// first goes into a 34-entry nibble memory, and the few annunciator nibbles are
// also captured as they arrive. After the last byte of a frame the input stalls
// while a sequencer reads the twelve digit nibbles from the memory, one per
// cycle with a single pause before the last read, and parses them into a signed
// mantissa and a decimal exponent. The result then goes into the output
// register once that register is free, and the input opens again. A result
// waiting on the master side does not block the bytes of the next frame, only
// the next frame's final load. A frame with any bad start or stop pattern gives
// a result with frame_ok low and all other fields zero.
module meter_lcd_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // raw_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // frame_ok, mantissa[20:0], decimal_exponent[5:0], has_letters, unit_code[2:0],
    // coupling[1:0], modifier[2:0], auto_range, hold, zero pad
    output logic [mlfd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_RECV,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        first;
        logic        neg;
        logic        dot;
        logic        stop;
        logic [19:0] mant;
        logic [2:0]  frac;
    } t_parse;

    function automatic t_parse parse_step(input t_parse st, input logic vld,
                                          input logic [3:0] code);
        t_parse    r;
        logic [23:0] prod;
        r    = st;
        prod = ({4'b0, st.mant} << 3) + ({4'b0, st.mant} << 1) + {20'b0, code};
        if (vld) begin
            if (st.first && code == mlfd_pkg::CH_MINUS) begin
                r.first = 1'b0;
                r.neg   = 1'b1;
            end else begin
                r.first = 1'b0;
                if (!st.stop) begin
                    if (code <= 4'd9) begin
                        r.mant = prod[19:0];
                        if (st.dot) begin
                            r.frac = st.frac + 3'd1;
                        end
                    end else if (code == mlfd_pkg::CH_DOT && !st.dot) begin
                        r.dot = 1'b1;
                    end else begin
                        r.stop = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    t_state r_state;
    logic [mlfd_pkg::POS_W-1:0]  r_pos;
    logic                        r_bad;
    logic                        r_res_bad;
    logic [mlfd_pkg::WALK_W-1:0] r_cnt;
    logic                        r_rd_vld;
    logic [mlfd_pkg::WALK_W-1:0] r_rd_idx;
    logic [3:0]                  r_rd_data;
    logic [3:0]                  r_hi;
    logic [3:0]                  r_mem [mlfd_pkg::STORE_DEPTH];
    t_parse                      r_parse;
    t_parse                      n_parse;
    logic                        r_letters;
    logic [7:0]                  r_sw;
    logic [7:0]                  r_f1;
    logic [7:0]                  r_f2;
    logic [3:0]                  r_f15_lo;
    logic [3:0]                  r_f16_hi;
    logic                        r_m_tvalid;
    logic [mlfd_pkg::OUT_DATA_W-1:0] r_m_tdata;

    logic                        s_acc;
    logic                        byte_bad;
    logic                        last_byte;
    logic                        wr_en;
    logic [mlfd_pkg::ADDR_W-1:0] wr_addr;
    logic [mlfd_pkg::ADDR_W-1:0] rd_addr;
    logic                        walk_rd;
    logic                        walk_end;

    logic [7:0]  digit;
    logic        digit0;
    logic        a_vld;
    logic [3:0]  a_code;
    logic [3:0]  seg_k;
    logic        b_vld;
    logic [3:0]  b_code;
    logic        letter_hit;

    logic [7:0]  sw;
    logic [3:0]  sp;
    logic [2:0]  unit;
    logic [1:0]  coup;
    logic [2:0]  modif;
    logic        dbm;
    logic        pct;
    logic [5:0]  expo;
    logic [20:0] mant_s;
    logic        load_out;
    logic [mlfd_pkg::OUT_DATA_W-1:0] res_data;

    assign o_s_axis_tready = (r_state == S_RECV);
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign byte_bad  = (i_s_axis_tdata[1:0] != 2'b01) || (i_s_axis_tdata[7:6] != 2'b11);
    assign last_byte = (r_pos == mlfd_pkg::POS_W'(mlfd_pkg::FRAME_BYTES - 1));
    assign wr_en     = s_acc && (r_pos != '0);
    assign wr_addr   = mlfd_pkg::ADDR_W'(r_pos - mlfd_pkg::POS_W'(1));
    assign walk_rd   = (r_state == S_WALK) &&
                       (r_cnt != mlfd_pkg::WALK_W'(mlfd_pkg::WALK_READS - 1) || !r_rd_vld)
                       && !(r_rd_vld && r_rd_idx == mlfd_pkg::WALK_W'(mlfd_pkg::WALK_READS - 1));
    assign rd_addr   = mlfd_pkg::ADDR_W'(mlfd_pkg::DIGIT_BASE) +
                       mlfd_pkg::ADDR_W'(r_cnt);
    assign walk_end  = r_rd_vld && r_rd_idx == mlfd_pkg::WALK_W'(mlfd_pkg::WALK_READS - 1);

    // nibble memory of the frame, read back for the digit field
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_s_axis_tdata[5:2];
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // one digit: optional point or sign code, then the segment character
    always_comb begin
        digit      = {r_hi, r_rd_data};
        digit0     = (r_rd_idx[mlfd_pkg::WALK_W-1:1] == '0);
        a_vld      = digit[7];
        a_code     = digit0 ? mlfd_pkg::CH_MINUS : mlfd_pkg::CH_DOT;
        seg_k      = mlfd_pkg::seg_lookup(digit[6:0]);
        b_vld      = (digit[6:0] != 7'd0) && (seg_k != mlfd_pkg::SEG_NONE);
        if (seg_k <= 4'd9) begin
            b_code = seg_k;
        end else if (seg_k == 4'd14) begin
            b_code = mlfd_pkg::CH_MINUS;
        end else begin
            b_code = mlfd_pkg::CH_LETTER;
        end
        letter_hit = b_vld && (seg_k >= 4'd10);
        n_parse    = parse_step(parse_step(r_parse, a_vld, a_code), b_vld, b_code);
    end

    // result fields
    always_comb begin
        sw  = ~r_sw;
        dbm = r_f1[0];
        pct = r_f15_lo[3];
        if (sw == 8'd0) begin
            sp = 4'd0;
        end else if (sw[7:4] != 4'd0) begin
            sp = 4'd5 - {1'b0, mlfd_pkg::bit_pos(sw[7:4])};
        end else begin
            sp = 4'd4 + {1'b0, mlfd_pkg::bit_pos(sw[3:0])};
        end
        if (dbm) begin
            unit = mlfd_pkg::UNIT_DBM;
        end else if (pct) begin
            unit = mlfd_pkg::UNIT_PCT;
        end else if (sp < 4'd9) begin
            unit = mlfd_pkg::UNIT_OF_SWITCH[sp];
        end else begin
            unit = mlfd_pkg::UNIT_V;
        end

        if (r_f2[3] && r_f2[2]) begin
            coup = mlfd_pkg::COUP_ACDC;
        end else if (r_f2[3]) begin
            coup = mlfd_pkg::COUP_AC;
        end else if (r_f2[2]) begin
            coup = mlfd_pkg::COUP_DC;
        end else begin
            coup = mlfd_pkg::COUP_NONE;
        end

        if (r_f16_hi[3]) begin
            modif = mlfd_pkg::MOD_DELTA;
        end else if (r_f16_hi[0]) begin
            modif = mlfd_pkg::MOD_PP;
        end else if (r_f16_hi[2]) begin
            modif = mlfd_pkg::MOD_MAX;
        end else if (r_f15_lo[1]) begin
            modif = mlfd_pkg::MOD_MIN;
        end else begin
            modif = mlfd_pkg::MOD_NONE;
        end

        expo = 6'd0;
        if (!dbm && !pct) begin
            if (r_f2[6]) begin
                expo = expo - 6'd9;
            end
            if (r_f1[2]) begin
                expo = expo - 6'd6;
            end
            if (r_f1[1]) begin
                expo = expo - 6'd3;
            end
            if (r_f1[6]) begin
                expo = expo + 6'd3;
            end
            if (r_f1[7]) begin
                expo = expo + 6'd6;
            end
        end
        expo = expo - {3'd0, r_parse.frac};

        mant_s = r_parse.neg ? (21'd0 - {1'b0, r_parse.mant}) : {1'b0, r_parse.mant};

        if (r_res_bad) begin
            res_data = '0;
        end else begin
            res_data = {1'b0, r_f2[1], r_f2[0], modif, coup, unit, r_letters,
                        expo, mant_s, 1'b1};
        end
        load_out = (r_state == S_DONE) && (!r_m_tvalid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RECV;
            r_pos      <= '0;
            r_bad      <= 1'b0;
            r_res_bad  <= 1'b0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_m_tvalid <= 1'b0;
            r_parse    <= '0;
            r_letters  <= 1'b0;
        end else begin
            if (load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_RECV: begin
                    if (s_acc) begin
                        if (last_byte) begin
                            r_pos      <= '0;
                            r_bad      <= 1'b0;
                            r_res_bad  <= r_bad || byte_bad;
                            r_cnt      <= '0;
                            r_rd_vld   <= 1'b0;
                            r_parse    <= '{first: 1'b1, default: '0};
                            r_letters  <= 1'b0;
                            r_state    <= S_WALK;
                        end else begin
                            r_pos <= r_pos + mlfd_pkg::POS_W'(1);
                            r_bad <= r_bad || byte_bad;
                        end
                    end
                end
                S_WALK: begin
                    r_rd_vld <= walk_rd;
                    r_rd_idx <= r_cnt;
                    if (walk_rd) begin
                        r_cnt <= r_cnt + mlfd_pkg::WALK_W'(1);
                    end
                    if (r_rd_vld && r_rd_idx[0]) begin
                        r_parse <= n_parse;
                        if (letter_hit) begin
                            r_letters <= 1'b1;
                        end
                    end
                    if (walk_end) begin
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_RECV;
                    end
                end
                default: begin
                    r_state <= S_RECV;
                end
            endcase
        end
    end

    // payload registers: high digit nibble, annunciator nibbles, result
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !r_rd_idx[0]) begin
            r_hi <= r_rd_data;
        end
        if (wr_en) begin
            case (wr_addr)
                mlfd_pkg::ADDR_W'(0):  r_sw[7:4]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(1):  r_sw[3:0]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(2):  r_f1[7:4]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(3):  r_f1[3:0]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(4):  r_f2[7:4]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(5):  r_f2[3:0]  <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(31): r_f15_lo   <= i_s_axis_tdata[5:2];
                mlfd_pkg::ADDR_W'(32): r_f16_hi   <= i_s_axis_tdata[5:2];
                default: ;
            endcase
        end
        if (load_out) begin
            r_m_tdata <= res_data;
        end
    end

endmodule
